// ===== rtl/mfr_pkg.sv =====
// Package with the shared types and constants of the meter frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package mfr_pkg;

  // Control characters of the meter link.
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_STX = 8'h02;
  localparam logic [7:0] CHAR_ETX = 8'h03;
  localparam logic [7:0] CHAR_ACK = 8'h06;
  localparam logic [7:0] CHAR_NAK = 8'h15;

  // Result field widths.
  localparam int unsigned LEN_W = 9;
  localparam int unsigned BCC_W = 7;
  localparam logic [LEN_W-1:0] LEN_MAX = 9'd511;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRAME_MODE     = 2'd0;
  localparam logic [1:0] CFG_LEAD_BYTE      = 2'd1;
  localparam logic [1:0] CFG_ACCEPT_ACK_NAK = 2'd2;
  localparam logic [1:0] CFG_CHECK_BCC      = 2'd3;

  // Input operation codes.
  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // Frame mode codes.
  localparam logic MODE_LINE = 1'b0;
  localparam logic MODE_PROG = 1'b1;

  typedef enum logic [1:0] {
    KIND_LINE = 2'd0,
    KIND_PROG = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_NAK  = 2'd3
  } frame_kind_e;

  typedef struct packed {
    logic       frame_mode;
    logic [7:0] lead_byte;
    logic       accept_ack_nak;
    logic       check_bcc;
  } mfr_cfg_t;

  typedef struct packed {
    logic              frame_done;
    frame_kind_e       frame_kind;
    logic [LEN_W-1:0]  frame_length;
    logic              bcc_ok;
    logic [BCC_W-1:0]  bcc_value;
  } mfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/mfr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/mfr_window.sv =====
// Sliding byte window, running block check and frame end detection.
`timescale 1ns / 1ps
`default_nettype none

module mfr_window #(
  parameter int unsigned WINDOW_DEPTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                op_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire mfr_pkg::mfr_cfg_t   cfg_i,
  output mfr_pkg::mfr_result_t     result_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned LW = (FW > mfr_pkg::LEN_W) ? FW : mfr_pkg::LEN_W;
  localparam int unsigned BW = mfr_pkg::BCC_W;

  // Window state.
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] rdp_q, rdp_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [BW-1:0] sum_q, sum_d;
  logic [7:0]    prev_q, prev_d;
  logic [7:0]    first_q, first_d;
  logic [7:0]    second_q, second_d;
  logic          byp_q;
  logic [7:0]    byp_data_q;
  logic [7:0]    rdata;
  logic [7:0]    third;
  logic          ram_we;

  // Per-byte working values.
  logic          full;
  logic [FW-1:0] fill_a;
  logic [BW-1:0] sum_a;
  logic [BW-1:0] sum_b;
  logic [FW-1:0] len;
  logic [LW-1:0] len_x;
  logic [7:0]    first;
  logic [BW-1:0] bcc;
  logic          done;
  mfr_pkg::frame_kind_e kind;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] rdp_inc;

  assign ram_we = step_i && (op_i == mfr_pkg::OP_RECEIVE);

  // The ring read port always prefetches the third-oldest byte of the window.
  mfr_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(head_q),
    .wdata_i(rx_byte_i),
    .raddr_i(rdp_d),
    .rdata_o(rdata)
  );

  // Forward a byte written to the prefetch address in the same cycle.
  always_ff @(posedge clk_i) begin
    byp_q      <= ram_we && (head_q == rdp_d);
    byp_data_q <= rx_byte_i;
  end

  assign third = byp_q ? byp_data_q : rdata;

  assign head_inc = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign rdp_inc  = (rdp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : rdp_q + 1'b1;

  // Window update: drop the oldest byte when full, then take the new one.
  always_comb begin
    full   = (fill_q == FW'(WINDOW_DEPTH));
    fill_a = full ? FW'(WINDOW_DEPTH - 1) : fill_q;
    sum_a  = full ? (sum_q - second_q[BW-1:0]) : sum_q;
    sum_b  = (fill_a != '0) ? (sum_a + rx_byte_i[BW-1:0]) : sum_a;
    len    = fill_a + 1'b1;
    len_x  = LW'(len);
    if (fill_q == '0) begin
      first = rx_byte_i;
    end else if (full) begin
      first = second_q;
    end else begin
      first = first_q;
    end
    bcc = (fill_a != '0) ? (sum_b - rx_byte_i[BW-1:0]) : '0;
  end

  // Frame end detection for both modes.
  always_comb begin
    done = 1'b0;
    kind = mfr_pkg::KIND_LINE;
    if (cfg_i.frame_mode == mfr_pkg::MODE_LINE) begin
      if ((fill_a != '0) && (rx_byte_i == mfr_pkg::CHAR_LF) &&
          (prev_q == mfr_pkg::CHAR_CR)) begin
        done = 1'b1;
      end
    end else if (cfg_i.accept_ack_nak && (fill_a == '0) &&
                 (first == mfr_pkg::CHAR_ACK)) begin
      done = 1'b1;
      kind = mfr_pkg::KIND_ACK;
    end else if (cfg_i.accept_ack_nak && (fill_a == '0) &&
                 (first == mfr_pkg::CHAR_NAK)) begin
      done = 1'b1;
      kind = mfr_pkg::KIND_NAK;
    end else if ((fill_a >= FW'(3)) && (first == cfg_i.lead_byte) &&
                 (prev_q == mfr_pkg::CHAR_ETX)) begin
      done = 1'b1;
      kind = mfr_pkg::KIND_PROG;
    end
  end

  // Result of the current transaction; all zero unless a frame ends.
  always_comb begin
    result_o = '0;
    if ((op_i == mfr_pkg::OP_RECEIVE) && done) begin
      result_o.frame_done   = 1'b1;
      result_o.frame_kind   = kind;
      result_o.frame_length = (len_x > LW'(mfr_pkg::LEN_MAX)) ?
                              mfr_pkg::LEN_MAX : len_x[mfr_pkg::LEN_W-1:0];
      result_o.bcc_value    = bcc;
      if ((kind == mfr_pkg::KIND_ACK) || (kind == mfr_pkg::KIND_NAK) ||
          !cfg_i.check_bcc) begin
        result_o.bcc_ok = 1'b1;
      end else begin
        result_o.bcc_ok = !rx_byte_i[7] && (bcc == rx_byte_i[BW-1:0]);
      end
    end
  end

  // Next state: clear on request or after a frame, otherwise slide.
  always_comb begin
    head_d   = head_q;
    rdp_d    = rdp_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    prev_d   = prev_q;
    first_d  = first_q;
    second_d = second_q;
    if (step_i) begin
      if ((op_i == mfr_pkg::OP_CLEAR) || done) begin
        head_d = '0;
        rdp_d  = AW'(2);
        fill_d = '0;
        sum_d  = '0;
        prev_d = '0;
      end else begin
        head_d = head_inc;
        fill_d = len;
        sum_d  = sum_b;
        prev_d = rx_byte_i;
        if (fill_q == '0) begin
          first_d = rx_byte_i;
        end
        if (fill_q == FW'(1)) begin
          second_d = rx_byte_i;
        end
        if (full) begin
          first_d  = second_q;
          second_d = third;
          rdp_d    = rdp_inc;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      rdp_q  <= AW'(2);
      fill_q <= '0;
      sum_q  <= '0;
      prev_q <= '0;
    end else begin
      head_q <= head_d;
      rdp_q  <= rdp_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
      prev_q <= prev_d;
    end
  end

  // Oldest and second-oldest bytes of the window.
  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

  // The fill count never exceeds the window depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WINDOW_DEPTH))
    else $error("window fill count above depth");

  // A completed frame leaves an empty window behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.frame_done |=> (fill_q == '0) && (sum_q == '0))
    else $error("window not cleared after frame end");

  // While the window is empty, head and prefetch pointers sit at their reset values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (head_q == '0) && (rdp_q == AW'(2)))
    else $error("empty window with moved pointers");

endmodule

`default_nettype wire

// ===== rtl/meter_frame_receiver_bcc_core.sv =====
// Top level of the meter frame receiver: handshakes, configuration and registers.
//
// Usage: received bytes enter on the input channel (in_valid_i, in_stall_o,
// op_i, rx_byte_i); op_i set instead clears the window. Every input
// transaction yields exactly one result transaction on the output channel
// (out_valid_o, out_stall_i, frame_done_o, frame_kind_o, frame_length_o,
// bcc_ok_o, bcc_value_o); it is all zero unless the byte ended a frame.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i,
// one register per cycle, while no transaction is in flight.
// A transaction accepted into the input register is evaluated there and,
// once the result register is free, moves into the result register,
// from which it is offered on the output channel.
// Throughput is one transaction per cycle while out_stall_i holds no
// result, limited by the single ring write port and the running-sum update.
// When out_stall_i holds a result, the input register can still take one
// more transaction; after that in_stall_o rises.
// Reset clears the window, the handshake state and sets the registers to
// programming mode, start byte STX, ACK/NAK frames off, block check on.
// The ring memory itself is not cleared: only bytes written since the
// last clear are ever read.
`timescale 1ns / 1ps
`default_nettype none

module meter_frame_receiver_bcc_core #(
  parameter int unsigned WINDOW_DEPTH = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration write port.
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  // Input channel.
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       op_i,
  input  wire logic [7:0] rx_byte_i,
  // Output channel.
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            frame_done_o,
  output logic [1:0]      frame_kind_o,
  output logic [8:0]      frame_length_o,
  output logic            bcc_ok_o,
  output logic [6:0]      bcc_value_o
);

  mfr_pkg::mfr_cfg_t    cfg_q, cfg_d;
  mfr_pkg::mfr_result_t result;
  mfr_pkg::mfr_result_t res_q;

  logic       in_valid_q, in_valid_d;
  logic       in_op_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  logic       in_accept;
  logic       advance;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        mfr_pkg::CFG_FRAME_MODE:     cfg_d.frame_mode     = cfg_data_i[0];
        mfr_pkg::CFG_LEAD_BYTE:      cfg_d.lead_byte      = cfg_data_i;
        mfr_pkg::CFG_ACCEPT_ACK_NAK: cfg_d.accept_ack_nak = cfg_data_i[0];
        mfr_pkg::CFG_CHECK_BCC:      cfg_d.check_bcc      = cfg_data_i[0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_mode     <= mfr_pkg::MODE_PROG;
      cfg_q.lead_byte      <= mfr_pkg::CHAR_STX;
      cfg_q.accept_ack_nak <= 1'b0;
      cfg_q.check_bcc      <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Handshake: the input register moves on whenever the result register is free.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q   <= op_i;
      in_byte_q <= rx_byte_i;
    end
  end

  // Window and frame evaluation.
  mfr_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .op_i     (in_op_q),
    .rx_byte_i(in_byte_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_done_o   = res_q.frame_done;
  assign frame_kind_o   = res_q.frame_kind;
  assign frame_length_o = res_q.frame_length;
  assign bcc_ok_o       = res_q.bcc_ok;
  assign bcc_value_o    = res_q.bcc_value;

  // Every evaluated transaction is presented in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluated transaction not presented");

  // The input side only stalls behind a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a held result");

  // A reported frame always has a nonzero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_done |-> (res_q.frame_length != '0))
    else $error("completed frame with zero length");

endmodule

`default_nettype wire
